### rtl/priority_aging_task_scheduler_defines.svh
// Assertion helpers shared by the RTL that checks itself.
// Every property is clocked on clk_i and is off while rst_ni is low.
`ifndef PRIORITY_AGING_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_AGING_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PATS_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define PATS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/pats_pkg.sv
package pats_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam int FUNC_W    = 2;
  localparam int SLOT_W    = 4;
  localparam int LVL_W     = 6;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  typedef logic signed [LVL_W-1:0] level_t;

  localparam level_t LEVEL_MIN = -6'sd20;
  localparam level_t LEVEL_MAX = 6'sd20;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND   = 2'd0,
    FUNC_SET_PRIO = 2'd1,
    FUNC_REMOVE   = 2'd2,
    FUNC_PICK     = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_NOT_LISTED = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_RELOAD = 6'b001000,
    ST_SHIFT  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  // Clamp a raw request level into the legal range.
  function automatic level_t sat_level(input level_t raw);
    level_t res;
    res = raw;
    if (raw < LEVEL_MIN) begin
      res = LEVEL_MIN;
    end else if (raw > LEVEL_MAX) begin
      res = LEVEL_MAX;
    end
    return res;
  endfunction

endpackage

### rtl/pats_ram.sv
module pats_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/priority_aging_task_scheduler.sv
// Priority scheduler with aging over an ordered ready list of task slots.
// Slave stream: one command per transaction. tuser carries the function
// (append, set priority, remove, pick next); tdata carries slot and level.
// Master stream: one response per command. tuser carries the status; tdata
// carries the chosen slot and the number of listed slots after the command.
// Levels live in a level RAM (static and dynamic level per slot), the list
// order in an order RAM; both have registered reads. Append, set priority
// and errors need no pass over the RAMs; remove makes one pass over the
// order RAM; pick scans both RAMs in series, then makes a compaction pass
// over the order RAM. Each pass covers the listed entries.
// One command is in flight at a time; the next is taken once the current
// response sits in the output register, even while that response stalls.
// A stalled master side holds the response and, after one more command,
// holds off the slave side. Reset empties the list; RAM contents are kept.
`include "priority_aging_task_scheduler_defines.svh"

module priority_aging_task_scheduler #(
  parameter int NUM_SLOTS = pats_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [3:0] slot, [9:4] priority_req, [15:10] zero
  input  logic [pats_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [pats_pkg::FUNC_W-1:0]    s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [3:0] chosen_slot, [8:4] listed_count, [15:9] zero
  output logic [pats_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [pats_pkg::STAT_W-1:0]    m_axis_tuser_o
);
  import pats_pkg::*;

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  state_e                 state_q, state_d;
  func_e                  cmd_func_q, cmd_func_d;
  logic [SLOT_W-1:0]      cmd_slot_q, cmd_slot_d;
  level_t                 cmd_lvl_q, cmd_lvl_d;
  logic [NUM_SLOTS-1:0]   listed_q, listed_d;
  cnt_t                   count_q, count_d;
  cnt_t                   rd_pos_q, rd_pos_d;
  logic                   v1_q, v1_d;
  idx_t                   p1_q, p1_d;
  logic                   v2_q, v2_d;
  idx_t                   p2_q, p2_d;
  idx_t                   s2_q, s2_d;
  level_t                 best_dyn_q, best_dyn_d;
  level_t                 best_stat_q, best_stat_d;
  idx_t                   best_pos_q, best_pos_d;
  idx_t                   best_slot_q, best_slot_d;
  logic                   found_q, found_d;
  status_e                res_status_q, res_status_d;
  logic [SLOT_W-1:0]      res_chosen_q, res_chosen_d;
  logic                   m_valid_q, m_valid_d;
  status_e                out_status_q, out_status_d;
  logic [SLOT_W-1:0]      out_chosen_q, out_chosen_d;
  logic [CNT_OUT_W-1:0]   out_count_q, out_count_d;

  logic                   ord_we;
  idx_t                   ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic                   lvl_we;
  idx_t                   lvl_waddr, lvl_raddr;
  logic [2*LVL_W-1:0]     lvl_wdata, lvl_rdata;

  level_t                 rd_dyn, rd_stat, aged;
  idx_t                   slot_idx;
  logic                   slot_ok;
  logic                   issue;
  logic                   match;

  pats_ram #(
    .Width (IdxW),
    .Depth (NUM_SLOTS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // Word layout: static level in the upper half, dynamic level in the lower.
  pats_ram #(
    .Width (2 * LVL_W),
    .Depth (NUM_SLOTS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  assign rd_dyn   = lvl_rdata[LVL_W-1:0];
  assign rd_stat  = lvl_rdata[2*LVL_W-1:LVL_W];
  assign aged     = (rd_dyn > LEVEL_MIN) ? level_t'(rd_dyn - level_t'(1)) : rd_dyn;
  assign slot_idx = idx_t'(cmd_slot_q);
  assign slot_ok  = int'(cmd_slot_q) < NUM_SLOTS;
  assign issue    = rd_pos_q < count_q;
  assign match    = (cmd_func_q == FUNC_PICK) ? (p1_q == best_pos_q)
                                              : (ord_rdata == slot_idx);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - SLOT_W - CNT_OUT_W){1'b0}},
                            out_count_q, out_chosen_q};

  always_comb begin
    state_d      = state_q;
    cmd_func_d   = cmd_func_q;
    cmd_slot_d   = cmd_slot_q;
    cmd_lvl_d    = cmd_lvl_q;
    listed_d     = listed_q;
    count_d      = count_q;
    rd_pos_d     = rd_pos_q;
    v1_d         = 1'b0;
    p1_d         = p1_q;
    v2_d         = 1'b0;
    p2_d         = p2_q;
    s2_d         = s2_q;
    best_dyn_d   = best_dyn_q;
    best_stat_d  = best_stat_q;
    best_pos_d   = best_pos_q;
    best_slot_d  = best_slot_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_chosen_d = res_chosen_q;
    m_valid_d    = m_valid_q & ~m_axis_tready_i;
    out_status_d = out_status_q;
    out_chosen_d = out_chosen_q;
    out_count_d  = out_count_q;

    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    ord_raddr = rd_pos_q[IdxW-1:0];
    lvl_we    = 1'b0;
    lvl_waddr = '0;
    lvl_wdata = '0;
    lvl_raddr = ord_rdata;

    // Walk the list positions in order; shared by both scan passes.
    if ((state_q == ST_SCAN || state_q == ST_SHIFT) && issue) begin
      rd_pos_d = rd_pos_q + cnt_t'(1);
      v1_d     = 1'b1;
      p1_d     = rd_pos_q[IdxW-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_func_d = func_e'(s_axis_tuser_i);
          cmd_slot_d = s_axis_tdata_i[SLOT_W-1:0];
          cmd_lvl_d  = sat_level(s_axis_tdata_i[SLOT_W+LVL_W-1:SLOT_W]);
          state_d    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rd_pos_d     = '0;
        found_d      = 1'b0;
        res_status_d = STAT_OK;
        res_chosen_d = '0;
        state_d      = ST_RESP;
        if (cmd_func_q == FUNC_PICK) begin
          if (count_q == '0) begin
            res_status_d = STAT_EMPTY;
          end else begin
            state_d = ST_SCAN;
          end
        end else if (!slot_ok) begin
          res_status_d = STAT_NOT_LISTED;
        end else begin
          case (cmd_func_q)
            FUNC_APPEND: begin
              if (listed_q[slot_idx] || count_q >= cnt_t'(NUM_SLOTS)) begin
                res_status_d = STAT_FULL;
              end else begin
                lvl_we             = 1'b1;
                lvl_waddr          = slot_idx;
                lvl_wdata          = {cmd_lvl_q, cmd_lvl_q};
                ord_we             = 1'b1;
                ord_waddr          = count_q[IdxW-1:0];
                ord_wdata          = slot_idx;
                listed_d[slot_idx] = 1'b1;
                count_d            = count_q + cnt_t'(1);
              end
            end
            FUNC_SET_PRIO: begin
              lvl_we    = 1'b1;
              lvl_waddr = slot_idx;
              lvl_wdata = {cmd_lvl_q, cmd_lvl_q};
            end
            FUNC_REMOVE: begin
              if (!listed_q[slot_idx]) begin
                res_status_d = STAT_NOT_LISTED;
              end else begin
                listed_d[slot_idx] = 1'b0;
                state_d            = ST_SHIFT;
              end
            end
            default: begin
              res_status_d = STAT_OK;
            end
          endcase
        end
      end

      // Order RAM feeds the level RAM address; compare and age on return.
      ST_SCAN: begin
        if (v1_q) begin
          v2_d = 1'b1;
          s2_d = ord_rdata;
          p2_d = p1_q;
        end
        if (v2_q) begin
          if (p2_q == '0 || rd_dyn < best_dyn_q) begin
            best_dyn_d  = rd_dyn;
            best_stat_d = rd_stat;
            best_pos_d  = p2_q;
            best_slot_d = s2_q;
          end
          lvl_we    = 1'b1;
          lvl_waddr = s2_q;
          lvl_wdata = {rd_stat, aged};
        end
        if (!issue && !v1_q && !v2_q) begin
          state_d = ST_RELOAD;
        end
      end

      ST_RELOAD: begin
        lvl_we                = 1'b1;
        lvl_waddr             = best_slot_q;
        lvl_wdata             = {best_stat_q, best_stat_q};
        listed_d[best_slot_q] = 1'b0;
        res_chosen_d          = SLOT_W'(best_slot_q);
        rd_pos_d              = '0;
        found_d               = 1'b0;
        state_d               = ST_SHIFT;
      end

      // Close the gap: after the match, move each entry down one position.
      ST_SHIFT: begin
        if (v1_q) begin
          if (found_q) begin
            ord_we    = 1'b1;
            ord_waddr = idx_t'(p1_q - idx_t'(1));
            ord_wdata = ord_rdata;
          end else if (match) begin
            found_d = 1'b1;
          end
        end
        if (!issue && !v1_q) begin
          count_d = count_q - cnt_t'(1);
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_chosen_d = res_chosen_q;
          out_count_d  = CNT_OUT_W'(count_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      listed_q  <= '0;
      count_q   <= '0;
      rd_pos_q  <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      listed_q  <= listed_d;
      count_q   <= count_d;
      rd_pos_q  <= rd_pos_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_func_q   <= cmd_func_d;
    cmd_slot_q   <= cmd_slot_d;
    cmd_lvl_q    <= cmd_lvl_d;
    p1_q         <= p1_d;
    p2_q         <= p2_d;
    s2_q         <= s2_d;
    best_dyn_q   <= best_dyn_d;
    best_stat_q  <= best_stat_d;
    best_pos_q   <= best_pos_d;
    best_slot_q  <= best_slot_d;
    res_status_q <= res_status_d;
    res_chosen_q <= res_chosen_d;
    out_status_q <= out_status_d;
    out_chosen_q <= out_chosen_d;
    out_count_q  <= out_count_d;
  end

  `PATS_ASSERT_IMPL(a_count_matches_flags, state_q == ST_IDLE,
                    $countones(listed_q) == int'(count_q),
                    "listed flags disagree with list length")
  `PATS_ASSERT_IMPL(a_chosen_is_listed, state_q == ST_RELOAD, listed_q[best_slot_q],
                    "picked slot is not on the list")
  `PATS_ASSERT_IMPL(a_shift_found, state_q == ST_SHIFT && !issue && !v1_q, found_q,
                    "compaction pass ended without finding its entry")
  `PATS_ASSERT_NEXT(a_resp_loads_output, state_q == ST_RESP && state_d == ST_IDLE, m_valid_q,
                    "response left without being presented")

endmodule

### test/priority_aging_task_scheduler_tb.sv
module priority_aging_task_scheduler_tb;
  import pats_pkg::*;

  localparam int SLOTS       = NUM_SLOTS_DEF;
  localparam int MAX_WAIT    = 6;
  localparam int DRAIN_CYC   = 2 * SLOTS + 16;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    status_e    status;
    logic [3:0] chosen;
    logic [4:0] count;
  } resp_t;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser_i  = FUNC_APPEND;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic [STAT_W-1:0]     m_axis_tuser_o;

  // Shadow of the scheduler state.
  bit     on_list [SLOTS];
  level_t base_lvl[SLOTS];
  level_t aged_lvl[SLOTS];
  int     run_q[$];

  resp_t  resp_due_q[$];
  bit     idle_on      = 1'b1;
  int     err_cnt      = 0;
  int     cmd_cnt      = 0;
  int     resp_cnt     = 0;
  int     chosen_cnt   = 0;
  int     bad_stat_cnt = 0;

  priority_aging_task_scheduler #(
    .NUM_SLOTS(SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("priority_aging_task_scheduler_tb: errors");
    $finish;
  end

  // Clamp a 6-bit request into -20..20.
  function automatic level_t clamp_level(input level_t raw);
    if (raw < LEVEL_MIN) begin
      return LEVEL_MIN;
    end
    if (raw > LEVEL_MAX) begin
      return LEVEL_MAX;
    end
    return raw;
  endfunction

  // Apply one command to the shadow state and return the response it must give.
  function automatic resp_t schedule_cmd(input func_e f, input logic [3:0] slot,
                                         input level_t raw);
    resp_t  r;
    int     best;
    int     s;
    level_t lvl;
    r.status = STAT_OK;
    r.chosen = '0;
    lvl      = clamp_level(raw);
    case (f)
      FUNC_PICK: begin
        if (run_q.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          chosen_cnt++;
          best = 0;
          for (int i = 1; i < run_q.size(); i++) begin
            if (aged_lvl[run_q[i]] < aged_lvl[run_q[best]]) begin
              best = i;
            end
          end
          foreach (run_q[i]) begin
            if (aged_lvl[run_q[i]] > LEVEL_MIN) begin
              aged_lvl[run_q[i]] = aged_lvl[run_q[i]] - 1;
            end
          end
          s           = run_q[best];
          aged_lvl[s] = base_lvl[s];
          on_list[s]  = 1'b0;
          run_q.delete(best);
          r.chosen    = s[3:0];
        end
      end
      FUNC_APPEND: begin
        if (on_list[slot] || run_q.size() >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          base_lvl[slot] = lvl;
          aged_lvl[slot] = lvl;
          on_list[slot]  = 1'b1;
          run_q.push_back(int'(slot));
        end
      end
      FUNC_SET_PRIO: begin
        base_lvl[slot] = lvl;
        aged_lvl[slot] = lvl;
      end
      default: begin
        if (!on_list[slot]) begin
          r.status = STAT_NOT_LISTED;
        end else begin
          foreach (run_q[i]) begin
            if (run_q[i] == int'(slot)) begin
              run_q.delete(i);
              break;
            end
          end
          on_list[slot] = 1'b0;
        end
      end
    endcase
    r.count = 5'(run_q.size());
    return r;
  endfunction

  // Send one command; returns at the edge where it was accepted, tvalid still high.
  task automatic send_cmd(input func_e f, input logic [3:0] slot, input level_t lvl);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= f;
    s_axis_tdata_i  <= {6'b0, lvl, slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    resp_due_q.push_back(schedule_cmd(f, slot, lvl));
    cmd_cnt++;
  endtask

  function automatic level_t rand_level();
    int r;
    int v;
    r = $urandom_range(0, 9);
    case (r)
      0:       v = $urandom_range(0, 63) - 32;
      1:       v = ($urandom_range(0, 1) != 0) ? 20 : -20 + $urandom_range(0, 1);
      2, 3, 4: v = $urandom_range(0, 4) - 2;
      default: v = $urandom_range(0, 40) - 20;
    endcase
    return level_t'(v);
  endfunction

  // Listed slot most of the time when want_listed, else an unlisted one.
  function automatic logic [3:0] rand_slot(input bit want_listed);
    int cand[$];
    if ($urandom_range(0, 4) == 0) begin
      return 4'($urandom_range(0, SLOTS - 1));
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (on_list[i] == want_listed) begin
        cand.push_back(i);
      end
    end
    if (cand.size() == 0) begin
      return 4'($urandom_range(0, SLOTS - 1));
    end
    return 4'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  task automatic test_directed();
    send_cmd(FUNC_PICK,     4'd0,  6'sd0);
    send_cmd(FUNC_APPEND,   4'd0,  6'b100000);
    send_cmd(FUNC_APPEND,   4'd15, 6'b011111);
    send_cmd(FUNC_APPEND,   4'd5,  LEVEL_MIN);
    send_cmd(FUNC_APPEND,   4'd0,  6'sd0);
    send_cmd(FUNC_SET_PRIO, 4'd7,  6'b010101);
    send_cmd(FUNC_REMOVE,   4'd7,  6'sd0);
    send_cmd(FUNC_SET_PRIO, 4'd15, 6'b101010);
    // three-way tie at the floor: head of the list wins, nobody ages below -20
    send_cmd(FUNC_PICK,     4'd0,  6'sd0);
    send_cmd(FUNC_APPEND,   4'd9,  6'sd3);
    send_cmd(FUNC_REMOVE,   4'd15, 6'sd0);
    send_cmd(FUNC_APPEND,   4'd7,  -6'sd5);
    send_cmd(FUNC_PICK,     4'd0,  6'sd0);
    send_cmd(FUNC_PICK,     4'd0,  6'sd0);
    send_cmd(FUNC_PICK,     4'd0,  6'sd0);
    send_cmd(FUNC_PICK,     4'd0,  6'sd0);
  endtask

  // Fill every slot in shuffled order, try one more, then drain by picks.
  task automatic test_full_list();
    int order[SLOTS];
    foreach (order[i]) begin
      order[i] = i;
    end
    order.shuffle();
    foreach (order[i]) begin
      send_cmd(FUNC_APPEND, 4'(order[i]), rand_level());
    end
    send_cmd(FUNC_APPEND, 4'($urandom_range(0, SLOTS - 1)), rand_level());
    repeat (SLOTS + 1) send_cmd(FUNC_PICK, 4'($urandom_range(0, SLOTS - 1)), rand_level());
  endtask

  task automatic test_random(input int n_cmds, input int append_pct, input bit idle);
    int r;
    idle_on = idle;
    repeat (n_cmds) begin
      r = $urandom_range(0, 99);
      if (r < append_pct) begin
        send_cmd(FUNC_APPEND, rand_slot(1'b0), rand_level());
      end else if (r < append_pct + 15) begin
        send_cmd(FUNC_SET_PRIO, rand_slot(1'b1), rand_level());
      end else if (r < append_pct + 30) begin
        send_cmd(FUNC_REMOVE, rand_slot(1'b1), rand_level());
      end else begin
        send_cmd(FUNC_PICK, 4'($urandom_range(0, SLOTS - 1)), rand_level());
      end
    end
  endtask

  // Response side: random stall before each transaction while idle_on is set.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin : check_resp
    resp_t due;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      resp_cnt++;
      if (resp_due_q.size() == 0) begin
        $error("response with no command pending: status %0d tdata 0x%04h",
               m_axis_tuser_o, m_axis_tdata_o);
        err_cnt++;
      end else begin
        due = resp_due_q.pop_front();
        if (due.status != STAT_OK) begin
          bad_stat_cnt++;
        end
        if (m_axis_tuser_o != due.status) begin
          $error("status: expected %0d, actual %0d", due.status, m_axis_tuser_o);
          err_cnt++;
        end
        if (m_axis_tdata_o[3:0] != due.chosen) begin
          $error("chosen_slot: expected %0d, actual %0d", due.chosen, m_axis_tdata_o[3:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[8:4] != due.count) begin
          $error("listed_count: expected %0d, actual %0d", due.count, m_axis_tdata_o[8:4]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    test_directed();
    test_full_list();
    test_random(300, 40, 1'b1);
    test_random(200, 55, 1'b0);
    test_random(300, 25, 1'b1);
    test_random(200, 40, 1'b1);
    s_axis_tvalid_i <= 1'b0;
    while (resp_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("Ran %0d commands with %0d responses checked.", cmd_cnt, resp_cnt);
    $display("Picks on a non-empty list: %0d, responses with an error status: %0d.",
             chosen_cnt, bad_stat_cnt);
    if (err_cnt == 0) begin
      $display("priority_aging_task_scheduler_tb: clean");
    end else begin
      $display("priority_aging_task_scheduler_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/pats_pkg.sv
rtl/pats_ram.sv
rtl/priority_aging_task_scheduler.sv
test/priority_aging_task_scheduler_tb.sv
